/* src/shs_pkg.sv */
// Shared constants, codes and helpers of the symbol histogram sampler.
package shs_pkg;

  // Table geometry.
  localparam int MAX_SLOTS = 28;
  localparam int COUNT_W   = 32;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int USED_W    = $clog2(MAX_SLOTS + 1);

  // Fixed field widths of the stream payloads.
  localparam int ACTION_W = 2;
  localparam int BYTE_W   = 8;
  localparam int FRAC_W   = 32;
  localparam int OSLOT_W  = 5;
  localparam int STATUS_W = 3;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  // Request actions.
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_COUNT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DRAW  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_COUNTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DRAWN    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd5;

  // Symbols that the histogram keeps.
  localparam logic [BYTE_W-1:0] CHAR_NL    = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CHAR_A     = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_Z     = 8'h7a;

  // True for space, newline and the lowercase letters.
  function automatic logic is_symbol(input logic [BYTE_W-1:0] b);
    is_symbol = b inside {CHAR_NL, CHAR_SPACE, [CHAR_A:CHAR_Z]};
  endfunction

endpackage

/* src/shs_scale.sv */
// Registered multiplier that scales a random fraction by the running total.
module shs_scale (
  input  logic                         clk,
  input  logic                         start,
  input  logic [shs_pkg::FRAC_W-1:0]   frac,
  input  logic [shs_pkg::COUNT_W-1:0]  total,
  output logic [shs_pkg::COUNT_W-1:0]  target
);
  import shs_pkg::*;

  localparam int PROD_W = FRAC_W + COUNT_W;

  logic [PROD_W-1:0]  prod;
  logic [COUNT_W-1:0] target_r;

  // Full product; the target is its part above the fraction bits.
  assign prod = {{COUNT_W{1'b0}}, frac} * {{FRAC_W{1'b0}}, total};

  always_ff @(posedge clk) begin
    if (start) begin
      target_r <= prod[PROD_W-1:FRAC_W];
    end
  end

  assign target = target_r;

endmodule

/* src/symbol_histogram_sampler_unit.sv */
// Top level of the symbol histogram sampler: request control, slot table and output register.
//
// Each request is a clear, a count of one byte or a draw. Clears, ignored bytes, bytes
// refused for a full total, draws on an empty table and the first symbol of an empty table
// go from idle straight to the done state. Other counts and draws walk the slot table
// through its single read port, one slot a cycle. The symbol and count memories share one
// address; the draw target comes from one registered 32 by 32 multiplier, loaded as the
// draw is taken, before the first slot is read. One request is in flight at a time; a new
// request is taken while the previous result still waits in the output register.
module symbol_histogram_sampler_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // byte_in [7:0], random_fraction [39:8]
  input  logic [shs_pkg::IN_DATA_W-1:0]     in_tdata,
  // action [1:0]
  input  logic [shs_pkg::ACTION_W-1:0]      in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // symbol_out [7:0], slot_out [12:8], zero above
  output logic [shs_pkg::OUT_DATA_W-1:0]    out_tdata,
  // status [2:0]
  output logic [shs_pkg::STATUS_W-1:0]      out_tuser
);
  import shs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // Request fields.
  logic [ACTION_W-1:0] in_action;
  logic [BYTE_W-1:0]   in_byte;
  logic [FRAC_W-1:0]   in_frac;

  assign in_action = in_tuser;
  assign in_byte   = in_tdata[BYTE_W-1:0];
  assign in_frac   = in_tdata[BYTE_W+FRAC_W-1:BYTE_W];

  // Control and table state.
  logic [1:0]          state_r, state_nxt;
  logic                is_draw_r, is_draw_nxt;
  logic [BYTE_W-1:0]   sym_r, sym_nxt;
  logic [USED_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic                chk_valid_r, chk_valid_nxt;
  logic [SLOT_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic [COUNT_W-1:0]  run_r, run_nxt;
  logic [USED_W-1:0]   slots_used_r, slots_used_nxt;
  logic [COUNT_W-1:0]  total_r, total_nxt;

  // Pending result and output register.
  logic [BYTE_W-1:0]   res_sym_r, res_sym_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_sym_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_load;

  // Slot memories and their port.
  logic [BYTE_W-1:0]   sym_mem [MAX_SLOTS];
  logic [COUNT_W-1:0]  cnt_mem [MAX_SLOTS];
  logic [BYTE_W-1:0]   rd_sym_r;
  logic [COUNT_W-1:0]  rd_cnt_r;
  logic                rd_en;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  logic [BYTE_W-1:0]   wr_sym;
  logic [COUNT_W-1:0]  wr_cnt;

  // Draw arithmetic.
  logic                mul_start;
  logic [COUNT_W-1:0]  target;
  logic [COUNT_W-1:0]  run_sum;
  logic                hit;
  logic                last;

  assign run_sum = run_r + rd_cnt_r;
  assign hit     = chk_valid_r && (is_draw_r ? (run_sum > target) : (rd_sym_r == sym_r));
  assign last    = chk_valid_r && ((USED_W'(chk_idx_r) + USED_W'(1)) == slots_used_r);

  shs_scale u_scale (
    .clk    (clk),
    .start  (mul_start),
    .frac   (in_frac),
    .total  (total_r),
    .target (target)
  );

  // Next-state logic of the request sequencer.
  always_comb begin
    state_nxt      = state_r;
    is_draw_nxt    = is_draw_r;
    sym_nxt        = sym_r;
    rd_idx_nxt     = rd_idx_r;
    chk_valid_nxt  = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    run_nxt        = run_r;
    slots_used_nxt = slots_used_r;
    total_nxt      = total_r;
    res_sym_nxt    = res_sym_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    in_tready      = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = slots_used_r[SLOT_W-1:0];
    wr_sym         = sym_r;
    wr_cnt         = COUNT_W'(1);
    mul_start      = 1'b0;
    out_load       = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          res_sym_nxt  = '0;
          res_slot_nxt = '0;
          state_nxt    = S_DONE;
          case (in_action)
            ACT_CLEAR: begin
              slots_used_nxt = '0;
              total_nxt      = '0;
              res_status_nxt = ST_CLEARED;
            end
            ACT_COUNT: begin
              if (!is_symbol(in_byte)) begin
                res_status_nxt = ST_IGNORED;
              end else if (&total_r) begin
                res_status_nxt = ST_OVERFLOW;
              end else if (slots_used_r == '0) begin
                // First symbol of an empty table goes straight into slot zero.
                wr_en          = 1'b1;
                wr_addr        = '0;
                wr_sym         = in_byte;
                slots_used_nxt = USED_W'(1);
                total_nxt      = total_r + COUNT_W'(1);
                res_status_nxt = ST_COUNTED;
              end else begin
                state_nxt   = S_SCAN;
                is_draw_nxt = 1'b0;
                sym_nxt     = in_byte;
                rd_idx_nxt  = '0;
              end
            end
            ACT_DRAW: begin
              if (total_r == '0 || slots_used_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                state_nxt   = S_SCAN;
                is_draw_nxt = 1'b1;
                rd_idx_nxt  = '0;
                run_nxt     = '0;
                mul_start   = 1'b1;
              end
            end
            default: begin
              res_status_nxt = ST_IGNORED;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one slot read a cycle and check the slot read in the cycle before.
        if (rd_idx_r < slots_used_r) begin
          rd_en         = 1'b1;
          chk_valid_nxt = 1'b1;
          chk_idx_nxt   = rd_idx_r[SLOT_W-1:0];
          rd_idx_nxt    = rd_idx_r + USED_W'(1);
        end
        if (chk_valid_r && is_draw_r) begin
          run_nxt = run_sum;
        end
        if (hit || last) begin
          state_nxt     = S_DONE;
          chk_valid_nxt = 1'b0;
          res_sym_nxt   = '0;
          res_slot_nxt  = '0;
          if (is_draw_r) begin
            if (hit) begin
              res_sym_nxt    = rd_sym_r;
              res_slot_nxt   = chk_idx_r;
              res_status_nxt = ST_DRAWN;
            end else begin
              res_status_nxt = ST_EMPTY;
            end
          end else if (hit) begin
            // Known symbol: raise its count.
            wr_en          = 1'b1;
            wr_addr        = chk_idx_r;
            wr_cnt         = rd_cnt_r + COUNT_W'(1);
            total_nxt      = total_r + COUNT_W'(1);
            res_slot_nxt   = chk_idx_r;
            res_status_nxt = ST_COUNTED;
          end else if (slots_used_r == USED_W'(MAX_SLOTS)) begin
            res_status_nxt = ST_OVERFLOW;
          end else begin
            // New symbol takes the next free slot.
            wr_en          = 1'b1;
            slots_used_nxt = slots_used_r + USED_W'(1);
            total_nxt      = total_r + COUNT_W'(1);
            res_slot_nxt   = slots_used_r[SLOT_W-1:0];
            res_status_nxt = ST_COUNTED;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      chk_valid_r  <= 1'b0;
      slots_used_r <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      chk_valid_r  <= chk_valid_nxt;
      slots_used_r <= slots_used_nxt;
      total_r      <= total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    is_draw_r    <= is_draw_nxt;
    sym_r        <= sym_nxt;
    rd_idx_r     <= rd_idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    run_r        <= run_nxt;
    res_sym_r    <= res_sym_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_sym_r    <= res_sym_r;
      out_slot_r   <= res_slot_r;
      out_status_r <= res_status_r;
    end
  end

  // Slot table memories with a registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sym_mem[wr_addr] <= wr_sym;
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (rd_en) begin
      rd_sym_r <= sym_mem[rd_idx_r[SLOT_W-1:0]];
      rd_cnt_r <= cnt_mem[rd_idx_r[SLOT_W-1:0]];
    end
  end

  // Result stream.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - BYTE_W - OSLOT_W){1'b0}}, OSLOT_W'(out_slot_r), out_sym_r};
  assign out_tuser  = out_status_r;

`ifndef SYNTH
  // The table is empty exactly when the total is zero.
  a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (slots_used_r == '0) == (total_r == '0))
    else $error("slot usage and total disagree on an empty table");

  // The fill level never passes the table size.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slots_used_r <= USED_W'(MAX_SLOTS))
    else $error("slot usage beyond table size");

  // A slot under check always lies inside the used part of the table.
  a_check_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    chk_valid_r |-> (USED_W'(chk_idx_r) < slots_used_r))
    else $error("checked slot outside the used table");

  // A scan always ends in a pending result.
  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && (hit || last)) |=> (state_r == S_DONE))
    else $error("scan ended without a result");
`endif

endmodule

/* bench/symbol_histogram_sampler_unit_test.sv */
// Self-checking testbench for the symbol histogram sampler: directed and random requests.
module symbol_histogram_sampler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import shs_pkg::*;

  // The action code that the block leaves unused.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [BYTE_W-1:0]   symbol;
    logic [OSLOT_W-1:0]  slot;
    logic [STATUS_W-1:0] status;
  } sample_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [ACTION_W-1:0]   in_tuser = ACT_CLEAR;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  // Shadow copy of the histogram kept by the predictor.
  logic [BYTE_W-1:0]  shadow_symbol [MAX_SLOTS];
  logic [COUNT_W-1:0] shadow_count [MAX_SLOTS];
  int                 shadow_used = 0;
  logic [COUNT_W-1:0] shadow_total = '0;

  sample_result_t pending_results [$];
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  symbol_histogram_sampler_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Space, newline and the lowercase letters are the kept symbols.
  function automatic logic is_kept(input logic [BYTE_W-1:0] b);
    is_kept = (b == CHAR_NL) || (b == CHAR_SPACE) || (b >= CHAR_A && b <= CHAR_Z);
  endfunction

  // Maps 0 to 27 onto newline, space and then the letters.
  function automatic logic [BYTE_W-1:0] kept_symbol(input int idx);
    if (idx == 0) begin
      kept_symbol = CHAR_NL;
    end else if (idx == 1) begin
      kept_symbol = CHAR_SPACE;
    end else begin
      kept_symbol = CHAR_A + 8'(idx - 2);
    end
  endfunction

  // Applies one request to the shadow histogram and returns its expected result.
  function automatic sample_result_t histogram_predict(input logic [ACTION_W-1:0] act,
                                                       input logic [BYTE_W-1:0] b,
                                                       input logic [FRAC_W-1:0] frac);
    sample_result_t r;
    logic [63:0] product;
    logic [COUNT_W-1:0] target;
    logic [COUNT_W:0] running;
    int hit;
    logic found;
    r = '{symbol: '0, slot: '0, status: ST_IGNORED};
    case (act)
      ACT_CLEAR: begin
        shadow_used = 0;
        shadow_total = '0;
        r.status = ST_CLEARED;
      end
      ACT_COUNT: begin
        if (!is_kept(b)) begin
          r.status = ST_IGNORED;
        end else if (shadow_total == '1) begin
          r.status = ST_OVERFLOW;
        end else begin
          hit = -1;
          for (int i = 0; i < shadow_used; i++) begin
            if (hit < 0 && shadow_symbol[i] == b) hit = i;
          end
          if (hit >= 0) begin
            shadow_count[hit] = shadow_count[hit] + 1'b1;
            shadow_total = shadow_total + 1'b1;
            r.slot = OSLOT_W'(hit);
            r.status = ST_COUNTED;
          end else if (shadow_used >= MAX_SLOTS) begin
            r.status = ST_OVERFLOW;
          end else begin
            shadow_symbol[shadow_used] = b;
            shadow_count[shadow_used] = 1;
            r.slot = OSLOT_W'(shadow_used);
            r.status = ST_COUNTED;
            shadow_used = shadow_used + 1;
            shadow_total = shadow_total + 1'b1;
          end
        end
      end
      ACT_DRAW: begin
        if (shadow_total == '0 || shadow_used == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // Scale the fraction by the total, then find the first slot whose
          // running sum passes the target.
          product = 64'(frac) * 64'(shadow_total);
          target = product[63:32];
          running = '0;
          found = 1'b0;
          r.status = ST_EMPTY;
          for (int i = 0; i < shadow_used; i++) begin
            if (!found) begin
              running = running + shadow_count[i];
              if (running > target) begin
                found = 1'b1;
                r.symbol = shadow_symbol[i];
                r.slot = OSLOT_W'(i);
                r.status = ST_DRAWN;
              end
            end
          end
        end
      end
      default: r.status = ST_IGNORED;
    endcase
    return r;
  endfunction

  // Offers one request, with random idle cycles beforehand, and records its expectation.
  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b,
                              input logic [FRAC_W-1:0] frac);
    sample_result_t expected;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata <= {32'($urandom), 8'($urandom)};
      in_tuser <= ACTION_W'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {frac, b};
    in_tuser <= act;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected = histogram_predict(act, b, frac);
    pending_results.insert(pending_results.size(), expected);
  endtask

  // Holds the sender back until every outstanding result has been taken.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Draws on an empty table, before and after a clear.
  task automatic test_empty_table();
    send_request(ACT_DRAW, 8'h00, 32'h0000_0000);
    send_request(ACT_DRAW, 8'hff, 32'hffff_ffff);
    send_request(ACT_CLEAR, 8'hff, 32'hffff_ffff);
    send_request(ACT_DRAW, CHAR_A, 32'h8000_0000);
  endtask

  // Bytes at and around every boundary of the kept set, plus the unused action.
  task automatic test_byte_filter();
    logic [BYTE_W-1:0] probes [12];
    probes = '{8'h00, 8'h09, CHAR_NL, 8'h0b, 8'h1f, CHAR_SPACE, 8'h21, 8'h60,
               CHAR_A, CHAR_Z, 8'h7b, 8'hff};
    foreach (probes[i]) send_request(ACT_COUNT, probes[i], $urandom);
    send_request(ACT_COUNT, CHAR_A, 32'h0);
    send_request(ACT_UNUSED, CHAR_A, 32'hffff_ffff);
  endtask

  // Draws at the fraction extremes, then a clear empties the table again.
  task automatic test_draw_edges();
    send_request(ACT_DRAW, 8'h00, 32'h0000_0000);
    send_request(ACT_DRAW, 8'hff, 32'hffff_ffff);
    send_request(ACT_DRAW, 8'h55, 32'h8000_0000);
    send_request(ACT_CLEAR, 8'h00, 32'h0);
    send_request(ACT_DRAW, 8'haa, 32'h5555_5555);
    wait_drained();
  endtask

  // Clears, then counts all 28 symbols in a shuffled order to fill the table.
  task automatic fill_every_symbol();
    int order [MAX_SLOTS];
    int j;
    int tmp;
    foreach (order[i]) order[i] = i;
    for (int i = MAX_SLOTS - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    send_request(ACT_CLEAR, 8'($urandom), $urandom);
    foreach (order[i]) send_request(ACT_COUNT, kept_symbol(order[i]), $urandom);
  endtask

  // Mostly counts of a skewed symbol mix and draws, with noise and rare clears.
  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    int pick;
    logic [FRAC_W-1:0] frac;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    fill_every_symbol();
    for (int n = 0; n < n_items; n++) begin
      if (n == n_items / 2) wait_drained();
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(1) == 0) begin
          send_request(ACT_COUNT, CHAR_A + 8'($urandom_range(4)), $urandom);
        end else begin
          send_request(ACT_COUNT, kept_symbol($urandom_range(MAX_SLOTS - 1)), $urandom);
        end
      end else if (pick < 80) begin
        case ($urandom_range(9))
          0:       frac = '0;
          1:       frac = '1;
          default: frac = $urandom;
        endcase
        send_request(ACT_DRAW, 8'($urandom), frac);
      end else if (pick < 90) begin
        send_request(ACT_COUNT, 8'($urandom_range(255)), $urandom);
      end else if (pick < 97) begin
        send_request(ACT_UNUSED, 8'($urandom), $urandom);
      end else begin
        send_request(ACT_CLEAR, 8'($urandom), $urandom);
      end
    end
  endtask

  // Receiver readiness, stalling at the current rate.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compares every taken result with the oldest expectation.
  always @(posedge clk) begin
    sample_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result symbol %0d slot %0d status %0d", $time,
                 out_tdata[7:0], out_tdata[12:8], out_tuser);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[7:0] !== exp_r.symbol) begin
          $display("%0t: symbol expected %0d actual %0d", $time, exp_r.symbol, out_tdata[7:0]);
          error_count++;
        end
        if (out_tdata[12:8] !== exp_r.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, exp_r.slot, out_tdata[12:8]);
          error_count++;
        end
        if (out_tuser !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_tuser);
          error_count++;
        end
        if (out_tdata[15:13] !== 3'b000) begin
          $display("%0t: upper data bits expected 0 actual %0d", $time, out_tdata[15:13]);
          error_count++;
        end
      end
    end
  end

  // Guards against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("symbol_histogram_sampler_unit_test: errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_byte_filter();
    test_draw_edges();
    test_random_traffic(150, 0, 0);
    test_random_traffic(150, 56, 0);
    test_random_traffic(150, 0, 56);
    test_random_traffic(150, 18, 18);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("symbol_histogram_sampler_unit_test: clean");
    end else begin
      $display("symbol_histogram_sampler_unit_test: errors");
    end
    $finish;
  end

endmodule
